/* hw/rtl/ivw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instance value window cache package
// Table depth, derived widths, operation and status codes, and the command
// structure that the sequencer sends to the entry store.
// ----------------------------------------------------------------------------
package ivw_pkg;

  // Table geometry and derived widths.
  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CFG_W = 7;
  localparam int KEY_W = 64;
  localparam int VAL_W = 64;
  localparam int EPH_W = 64;
  localparam int OP_W  = 2;
  localparam int STS_W = 3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_EPOCH = 2'd2;

  // Status codes.
  localparam logic [STS_W-1:0] STS_OK          = 3'd0;
  localparam logic [STS_W-1:0] STS_NOT_YET     = 3'd1;
  localparam logic [STS_W-1:0] STS_TOO_OLD     = 3'd2;
  localparam logic [STS_W-1:0] STS_WRONG_EPOCH = 3'd3;
  localparam logic [STS_W-1:0] STS_ACCEPTED    = 3'd4;
  localparam logic [STS_W-1:0] STS_DROPPED     = 3'd5;

  // Commands from the sequencer to the entry store.
  typedef struct packed {
    logic             clr_all;
    logic             inv_en;
    logic [IDX_W-1:0] inv_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [KEY_W-1:0] wr_key;
    logic [VAL_W-1:0] wr_val;
    logic [IDX_W-1:0] key_raddr;
    logic [IDX_W-1:0] val_raddr;
  } store_cmd_t;

endpackage

/* hw/rtl/ivw_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instance value window cache channels
// Valid/ready channels for requests, results and the capacity register.
// ----------------------------------------------------------------------------

// Request channel.
interface ivw_in_if;
  logic                        valid;
  logic                        ready;
  logic [ivw_pkg::OP_W-1:0]    operation;
  logic [ivw_pkg::KEY_W-1:0]   instance_id;
  logic [ivw_pkg::VAL_W-1:0]   value_in;
  logic [ivw_pkg::EPH_W-1:0]   epoch_high;
  logic [ivw_pkg::EPH_W-1:0]   epoch_low;

  modport source (output valid, operation, instance_id, value_in, epoch_high, epoch_low,
                  input ready);
  modport sink (input valid, operation, instance_id, value_in, epoch_high, epoch_low,
                output ready);
endinterface

// Result channel.
interface ivw_out_if;
  logic                        valid;
  logic                        ready;
  logic [ivw_pkg::STS_W-1:0]   status;
  logic [ivw_pkg::VAL_W-1:0]   value_out;

  modport source (output valid, status, value_out, input ready);
  modport sink (input valid, status, value_out, output ready);
endinterface

// Capacity register write channel.
interface ivw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ivw_pkg::CFG_W-1:0]   cache_size;

  modport source (output valid, cache_size, input ready);
  modport sink (input valid, cache_size, output ready);
endinterface

/* hw/rtl/ivw_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instance value window cache entry store
// Key and value memories with registered synchronous reads, plus the per-entry
// valid flags, which reset and a new epoch clear at once.
// ----------------------------------------------------------------------------
module ivw_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ivw_pkg::store_cmd_t         cmd,
  output logic [ivw_pkg::KEY_W-1:0]   key_q,
  output logic                        vld_q,
  output logic [ivw_pkg::VAL_W-1:0]   val_q
);

  logic [ivw_pkg::KEY_W-1:0] key_mem [ivw_pkg::DEPTH];
  logic [ivw_pkg::VAL_W-1:0] val_mem [ivw_pkg::DEPTH];
  logic [ivw_pkg::DEPTH-1:0] valid_r;
  logic [ivw_pkg::KEY_W-1:0] key_q_r;
  logic                      vld_q_r;
  logic [ivw_pkg::VAL_W-1:0] val_q_r;

  // Valid flags: a new epoch clears all, an eviction clears one, an insert sets one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clr_all) begin
      valid_r <= '0;
    end else begin
      if (cmd.inv_en) begin
        valid_r[cmd.inv_idx] <= 1'b0;
      end
      if (cmd.wr_en) begin
        valid_r[cmd.wr_idx] <= 1'b1;
      end
    end
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      key_mem[cmd.wr_idx] <= cmd.wr_key;
      val_mem[cmd.wr_idx] <= cmd.wr_val;
    end
    key_q_r <= key_mem[cmd.key_raddr];
    vld_q_r <= valid_r[cmd.key_raddr];
    val_q_r <= val_mem[cmd.val_raddr];
  end

  assign key_q = key_q_r;
  assign vld_q = vld_q_r;
  assign val_q = val_q_r;

endmodule

/* hw/rtl/instance_value_window_cache_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instance value window cache
// Bounded table from consensus instance id to a 64-bit value handle, with
// push, query and new-epoch operations and smallest-id eviction.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one result for
// each. Every push or query that passes the epoch and forgotten-mark checks
// sweeps the key memory one entry per clock before its result is presented,
// and the next request is taken once that result is in the output register.
// Each eviction forced by a full table adds another sweep. A successful
// query reads the value memory after the sweep. New epochs, dropped pushes
// and rejected queries skip the sweep and present their result after the
// check. No clearing pass is needed after reset. A request may be
// transferred in while the previous result still waits on the output; the
// block then holds its own result until the output register is free. The
// capacity register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module instance_value_window_cache_unit (
  input  logic   clk,
  input  logic   rst_n,
  ivw_in_if.sink     in_chan,
  ivw_out_if.source  out_chan,
  ivw_cfg_if.sink    cfg_chan
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_VREAD  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  localparam int CMP_W = (ivw_pkg::CNT_W > ivw_pkg::CFG_W) ? ivw_pkg::CNT_W : ivw_pkg::CFG_W;

  // Control state.
  logic [2:0]                  state_r, state_nxt;
  logic [ivw_pkg::CFG_W-1:0]   cache_size_r, cache_size_nxt;
  logic [ivw_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [ivw_pkg::KEY_W-1:0]   mark_r, mark_nxt;
  logic [ivw_pkg::EPH_W-1:0]   cur_eph_r, cur_eph_nxt;
  logic [ivw_pkg::EPH_W-1:0]   cur_epl_r, cur_epl_nxt;
  logic                        iss_act_r, iss_act_nxt;
  logic                        cmp_act_r, cmp_act_nxt;
  logic                        match_r, match_nxt;
  logic                        best_vld_r, best_vld_nxt;
  logic                        free_vld_r, free_vld_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [ivw_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [ivw_pkg::KEY_W-1:0]   id_r, id_nxt;
  logic [ivw_pkg::VAL_W-1:0]   vin_r, vin_nxt;
  logic [ivw_pkg::EPH_W-1:0]   eph_r, eph_nxt;
  logic [ivw_pkg::EPH_W-1:0]   epl_r, epl_nxt;
  logic [ivw_pkg::IDX_W-1:0]   iss_r, iss_nxt;
  logic [ivw_pkg::IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [ivw_pkg::IDX_W-1:0]   match_idx_r, match_idx_nxt;
  logic [ivw_pkg::IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [ivw_pkg::KEY_W-1:0]   best_key_r, best_key_nxt;
  logic [ivw_pkg::IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [ivw_pkg::STS_W-1:0]   res_status_r, res_status_nxt;
  logic [ivw_pkg::VAL_W-1:0]   res_value_r, res_value_nxt;
  logic [ivw_pkg::STS_W-1:0]   out_status_r, out_status_nxt;
  logic [ivw_pkg::VAL_W-1:0]   out_value_r, out_value_nxt;

  // Store interface.
  ivw_pkg::store_cmd_t         cmd;
  logic [ivw_pkg::KEY_W-1:0]   key_q;
  logic                        vld_q;
  logic [ivw_pkg::VAL_W-1:0]   val_q;

  logic [CMP_W-1:0]            size_ext;
  logic [ivw_pkg::CNT_W-1:0]   cap;
  logic                        scan_last;

  ivw_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .key_q (key_q),
    .vld_q (vld_q),
    .val_q (val_q)
  );

  // Effective capacity: zero acts as one, anything above the depth as the depth.
  always_comb begin
    size_ext = CMP_W'(cache_size_r);
    if (cache_size_r == '0) begin
      cap = ivw_pkg::CNT_W'(1);
    end else if (size_ext > CMP_W'(ivw_pkg::DEPTH)) begin
      cap = ivw_pkg::CNT_W'(ivw_pkg::DEPTH);
    end else begin
      cap = ivw_pkg::CNT_W'(size_ext);
    end
  end

  assign scan_last = cmp_act_r && (cmp_idx_r == ivw_pkg::LAST_IDX);

  assign in_chan.ready   = (state_r == S_IDLE);
  assign cfg_chan.ready  = 1'b1;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.status = out_status_r;
  assign out_chan.value_out = out_value_r;

  // Sequencer: check, sweep the key memory, then act on what the sweep found.
  always_comb begin
    state_nxt      = state_r;
    cache_size_nxt = cache_size_r;
    count_nxt      = count_r;
    mark_nxt       = mark_r;
    cur_eph_nxt    = cur_eph_r;
    cur_epl_nxt    = cur_epl_r;
    iss_act_nxt    = iss_act_r;
    cmp_act_nxt    = cmp_act_r;
    match_nxt      = match_r;
    best_vld_nxt   = best_vld_r;
    free_vld_nxt   = free_vld_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    vin_nxt        = vin_r;
    eph_nxt        = eph_r;
    epl_nxt        = epl_r;
    iss_nxt        = iss_r;
    cmp_idx_nxt    = cmp_idx_r;
    match_idx_nxt  = match_idx_r;
    best_idx_nxt   = best_idx_r;
    best_key_nxt   = best_key_r;
    free_idx_nxt   = free_idx_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;

    cmd            = '0;
    cmd.key_raddr  = iss_r;
    cmd.val_raddr  = match_idx_r;
    cmd.wr_key     = id_r;
    cmd.wr_val     = vin_r;
    cmd.wr_idx     = free_idx_r;
    cmd.inv_idx    = best_idx_r;

    // Capacity register write.
    if (cfg_chan.valid) begin
      cache_size_nxt = cfg_chan.cache_size;
    end

    // The output register empties on a transfer.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt    = in_chan.operation;
          id_nxt    = in_chan.instance_id;
          vin_nxt   = in_chan.value_in;
          eph_nxt   = in_chan.epoch_high;
          epl_nxt   = in_chan.epoch_low;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        res_value_nxt = '0;
        iss_nxt       = '0;
        iss_act_nxt   = 1'b1;
        cmp_act_nxt   = 1'b0;
        match_nxt     = 1'b0;
        best_vld_nxt  = 1'b0;
        free_vld_nxt  = 1'b0;
        unique case (op_r)
          ivw_pkg::OP_PUSH: begin
            if (id_r < mark_r) begin
              res_status_nxt = ivw_pkg::STS_DROPPED;
              state_nxt      = S_FIN;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          ivw_pkg::OP_QUERY: begin
            if (eph_r != cur_eph_r || epl_r != cur_epl_r) begin
              res_status_nxt = ivw_pkg::STS_WRONG_EPOCH;
              state_nxt      = S_FIN;
            end else if (id_r < mark_r) begin
              res_status_nxt = ivw_pkg::STS_TOO_OLD;
              state_nxt      = S_FIN;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          ivw_pkg::OP_EPOCH: begin
            cmd.clr_all    = 1'b1;
            count_nxt      = '0;
            mark_nxt       = '0;
            cur_eph_nxt    = eph_r;
            cur_epl_nxt    = epl_r;
            res_status_nxt = ivw_pkg::STS_ACCEPTED;
            state_nxt      = S_FIN;
          end
          default: begin
            res_status_nxt = ivw_pkg::STS_DROPPED;
            state_nxt      = S_FIN;
          end
        endcase
      end

      S_SCAN: begin
        // Issue one key read a cycle.
        cmp_act_nxt = iss_act_r;
        cmp_idx_nxt = iss_r;
        if (iss_act_r) begin
          if (iss_r == ivw_pkg::LAST_IDX) begin
            iss_act_nxt = 1'b0;
          end else begin
            iss_nxt = iss_r + ivw_pkg::IDX_W'(1);
          end
        end
        // Compare the key read in the previous cycle.
        if (cmp_act_r) begin
          if (vld_q && key_q == id_r) begin
            match_nxt     = 1'b1;
            match_idx_nxt = cmp_idx_r;
          end
          if (vld_q && (!best_vld_r || key_q < best_key_r)) begin
            best_vld_nxt = 1'b1;
            best_idx_nxt = cmp_idx_r;
            best_key_nxt = key_q;
          end
          if (!vld_q && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
        end
        if (scan_last) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (op_r == ivw_pkg::OP_QUERY) begin
          if (match_r) begin
            state_nxt = S_VREAD;
          end else begin
            res_status_nxt = ivw_pkg::STS_NOT_YET;
            state_nxt      = S_FIN;
          end
        end else if (match_r) begin
          // Duplicate id: the table stays as it is.
          res_status_nxt = ivw_pkg::STS_ACCEPTED;
          state_nxt      = S_FIN;
        end else if (count_r >= cap && count_r != '0 && best_vld_r) begin
          // Table full: evict the smallest id, advance the mark, sweep again.
          cmd.inv_en = 1'b1;
          count_nxt  = count_r - ivw_pkg::CNT_W'(1);
          if (best_key_r == '1) begin
            mark_nxt = '1;
          end else begin
            mark_nxt = best_key_r + ivw_pkg::KEY_W'(1);
          end
          iss_nxt      = '0;
          iss_act_nxt  = 1'b1;
          cmp_act_nxt  = 1'b0;
          best_vld_nxt = 1'b0;
          free_vld_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end else begin
          // Insert into the lowest free slot.
          cmd.wr_en      = free_vld_r;
          count_nxt      = count_r + ivw_pkg::CNT_W'(1);
          res_status_nxt = ivw_pkg::STS_ACCEPTED;
          state_nxt      = S_FIN;
        end
      end

      S_VREAD: begin
        // The value memory has already been read at the matched slot.
        res_status_nxt = ivw_pkg::STS_OK;
        res_value_nxt  = val_q;
        state_nxt      = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cache_size_r <= ivw_pkg::CFG_W'(64);
      count_r      <= '0;
      mark_r       <= '0;
      cur_eph_r    <= '0;
      cur_epl_r    <= '0;
      iss_act_r    <= 1'b0;
      cmp_act_r    <= 1'b0;
      match_r      <= 1'b0;
      best_vld_r   <= 1'b0;
      free_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cache_size_r <= cache_size_nxt;
      count_r      <= count_nxt;
      mark_r       <= mark_nxt;
      cur_eph_r    <= cur_eph_nxt;
      cur_epl_r    <= cur_epl_nxt;
      iss_act_r    <= iss_act_nxt;
      cmp_act_r    <= cmp_act_nxt;
      match_r      <= match_nxt;
      best_vld_r   <= best_vld_nxt;
      free_vld_r   <= free_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    vin_r        <= vin_nxt;
    eph_r        <= eph_nxt;
    epl_r        <= epl_nxt;
    iss_r        <= iss_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    match_idx_r  <= match_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_key_r   <= best_key_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

endmodule

/* verif/instance_value_window_cache_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instance value window cache testbench
// Drives push, query and new-epoch requests into the cache, mirrors the table,
// forgotten mark and epoch in a behavioural model, and checks every result in
// order against the model or a row's given answer. A short directed table
// leads, then random phases at several capacities and varied idling both sides.
// ----------------------------------------------------------------------------
module instance_value_window_cache_unit_tb;

  // Operation code that the block must drop without effect.
  localparam logic [ivw_pkg::OP_W-1:0] OP_NONE = 2'd3;
  localparam logic [ivw_pkg::KEY_W-1:0] ALL_ONES = '1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [ivw_pkg::OP_W-1:0]  operation;
    logic [ivw_pkg::KEY_W-1:0] instance_id;
    logic [ivw_pkg::VAL_W-1:0] value_in;
    logic [ivw_pkg::EPH_W-1:0] epoch_high;
    logic [ivw_pkg::EPH_W-1:0] epoch_low;
  } request_t;

  typedef struct packed {
    logic [ivw_pkg::STS_W-1:0] status;
    logic [ivw_pkg::VAL_W-1:0] value_out;
  } answer_t;

  // One line of the directed table: either a request or a capacity write.
  typedef struct {
    bit                        is_cfg;
    logic [ivw_pkg::CFG_W-1:0] cache_size;
    request_t                  req;
    bit                        known;
    answer_t                   answer;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ivw_in_if  in_if ();
  ivw_out_if out_if ();
  ivw_cfg_if cfg_if ();

  instance_value_window_cache_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the table, the forgotten mark, the epoch and the capacity.
  logic [ivw_pkg::KEY_W-1:0] key_mem [ivw_pkg::DEPTH];
  logic [ivw_pkg::VAL_W-1:0] val_mem [ivw_pkg::DEPTH];
  bit                        slot_used [ivw_pkg::DEPTH];
  int                        fill = 0;
  logic [ivw_pkg::KEY_W-1:0] forgotten = '0;
  logic [ivw_pkg::EPH_W-1:0] cur_epoch_high = '0;
  logic [ivw_pkg::EPH_W-1:0] cur_epoch_low = '0;
  logic [ivw_pkg::CFG_W-1:0] capacity_reg = 7'd64;

  answer_t   awaited_answers [$];
  stim_row_t stim_rows [$];
  int        errors = 0;
  int        cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic [ivw_pkg::KEY_W-1:0] id_base = 64'd100;

  function automatic int find_key(input logic [ivw_pkg::KEY_W-1:0] key);
    for (int i = 0; i < ivw_pkg::DEPTH; i++) begin
      if (slot_used[i] && key_mem[i] == key) return i;
    end
    return -1;
  endfunction

  // Applies one request to the model and returns the answer it must produce.
  function automatic answer_t cache_answer(input request_t r);
    answer_t ans;
    int      cap;
    int      best;
    int      free_slot;
    int      hit;
    ans = '{status: ivw_pkg::STS_DROPPED, value_out: '0};
    case (r.operation)
      ivw_pkg::OP_PUSH: begin
        if (r.instance_id < forgotten) begin
          ans.status = ivw_pkg::STS_DROPPED;
        end else begin
          ans.status = ivw_pkg::STS_ACCEPTED;
          if (find_key(r.instance_id) < 0) begin
            cap = int'(capacity_reg);
            if (cap < 1) cap = 1;
            if (cap > ivw_pkg::DEPTH) cap = ivw_pkg::DEPTH;
            // Evict the smallest id until there is room under the capacity.
            while (fill >= cap && fill > 0) begin
              best = -1;
              for (int i = 0; i < ivw_pkg::DEPTH; i++) begin
                if (slot_used[i] && (best < 0 || key_mem[i] < key_mem[best])) best = i;
              end
              slot_used[best] = 1'b0;
              fill--;
              forgotten = (key_mem[best] == ALL_ONES) ? ALL_ONES : key_mem[best] + 64'd1;
            end
            free_slot = -1;
            for (int i = 0; i < ivw_pkg::DEPTH; i++) begin
              if (!slot_used[i] && free_slot < 0) free_slot = i;
            end
            slot_used[free_slot] = 1'b1;
            key_mem[free_slot] = r.instance_id;
            val_mem[free_slot] = r.value_in;
            fill++;
          end
        end
      end
      ivw_pkg::OP_QUERY: begin
        if (r.epoch_high != cur_epoch_high || r.epoch_low != cur_epoch_low) begin
          ans.status = ivw_pkg::STS_WRONG_EPOCH;
        end else if (r.instance_id < forgotten) begin
          ans.status = ivw_pkg::STS_TOO_OLD;
        end else begin
          hit = find_key(r.instance_id);
          if (hit >= 0) begin
            ans.status = ivw_pkg::STS_OK;
            ans.value_out = val_mem[hit];
          end else begin
            ans.status = ivw_pkg::STS_NOT_YET;
          end
        end
      end
      ivw_pkg::OP_EPOCH: begin
        for (int i = 0; i < ivw_pkg::DEPTH; i++) slot_used[i] = 1'b0;
        fill = 0;
        forgotten = '0;
        cur_epoch_high = r.epoch_high;
        cur_epoch_low = r.epoch_low;
        ans.status = ivw_pkg::STS_ACCEPTED;
      end
      default: ans.status = ivw_pkg::STS_DROPPED;
    endcase
    return ans;
  endfunction

  function automatic void add_item(input logic [ivw_pkg::OP_W-1:0] op,
                                   input logic [ivw_pkg::KEY_W-1:0] id,
                                   input logic [ivw_pkg::VAL_W-1:0] val,
                                   input logic [ivw_pkg::EPH_W-1:0] eh,
                                   input logic [ivw_pkg::EPH_W-1:0] el,
                                   input bit known = 1'b0,
                                   input logic [ivw_pkg::STS_W-1:0] sts = ivw_pkg::STS_DROPPED,
                                   input logic [ivw_pkg::VAL_W-1:0] vout = '0);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.cache_size = '0;
    row.req = '{operation: op, instance_id: id, value_in: val, epoch_high: eh, epoch_low: el};
    row.known = known;
    row.answer = '{status: sts, value_out: vout};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [ivw_pkg::CFG_W-1:0] size);
    stim_row_t row;
    row = '{is_cfg: 1'b1, cache_size: size, req: '0, known: 1'b0, answer: '0};
    stim_rows.push_back(row);
  endfunction

  // Random request shaped around a sliding id window so that most pushes and
  // queries land near the live entries and the forgotten mark.
  function automatic request_t next_random_request();
    request_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.value_in = {$urandom, $urandom};
    r.epoch_high = cur_epoch_high;
    r.epoch_low = cur_epoch_low;
    r.instance_id = {$urandom, $urandom};
    if (pick < 3) begin
      r.operation = ivw_pkg::OP_EPOCH;
      case ($urandom_range(3))
        0: {r.epoch_high, r.epoch_low} = {$urandom, $urandom, $urandom, $urandom};
        1: {r.epoch_high, r.epoch_low} = '0;
        2: r.epoch_low = {$urandom, $urandom};
        default: ;
      endcase
      id_base = $urandom_range(1) ? 64'($urandom_range(1000)) : {$urandom, $urandom};
    end else if (pick < 5) begin
      r.operation = OP_NONE;
      r.epoch_high = {$urandom, $urandom};
    end else if (pick < 55) begin
      // Pushes ignore the epoch, so it carries noise here.
      r.operation = ivw_pkg::OP_PUSH;
      r.instance_id = id_base + 64'($urandom_range(7));
      r.epoch_high = {$urandom, $urandom};
      r.epoch_low = {$urandom, $urandom};
      id_base = id_base + 64'($urandom_range(2));
    end else begin
      r.operation = ivw_pkg::OP_QUERY;
      r.instance_id = id_base - 64'd12 + 64'($urandom_range(20));
      if ($urandom_range(9) == 0) r.epoch_high[$urandom_range(63)] ^= 1'b1;
      if ($urandom_range(19) == 0) r.epoch_low = {$urandom, $urandom};
    end
    // Now and then an id from anywhere in the 64-bit space.
    if (r.operation != ivw_pkg::OP_EPOCH && $urandom_range(24) == 0) begin
      r.instance_id = {$urandom, $urandom};
    end
    return r;
  endfunction

  // Presents one request, waits for its transfer and records the answer due.
  task automatic issue(input request_t r, input bit known, input answer_t typed);
    answer_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= r.operation;
    in_if.instance_id <= r.instance_id;
    in_if.value_in    <= r.value_in;
    in_if.epoch_high  <= r.epoch_high;
    in_if.epoch_low   <= r.epoch_low;
    do @(posedge clk); while (!in_if.ready);
    predicted = cache_answer(r);
    awaited_answers.push_back(known ? typed : predicted);
  endtask

  // Stops sending and waits until every answer has come back.
  task automatic wait_all_answered();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [ivw_pkg::CFG_W-1:0] size);
    cfg_if.valid      <= 1'b1;
    cfg_if.cache_size <= size;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    capacity_reg = size;
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checking against the oldest outstanding answer.
  always @(posedge clk) begin : check_results
    answer_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_answers.size() == 0) begin
        $error("unexpected result: status %0d value_out %h", out_if.status, out_if.value_out);
        errors++;
      end else begin
        want = awaited_answers.pop_front();
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_if.status);
          errors++;
        end
        if (out_if.value_out !== want.value_out) begin
          $error("value_out: expected %h, actual %h", want.value_out, out_if.value_out);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int phase_cap [7];
    int phase_send [7];
    int phase_recv [7];
    int phase_items [7];

    phase_cap   = '{3, 1, 64, 5, 0, 127, 8};
    phase_send  = '{0, 82, 0, 30, 0, 30, 0};
    phase_recv  = '{0, 0, 82, 30, 0, 30, 0};
    phase_items = '{150, 100, 200, 150, 80, 150, 170};

    in_if.valid       <= 1'b0;
    in_if.operation   <= ivw_pkg::OP_PUSH;
    in_if.instance_id <= '0;
    in_if.value_in    <= '0;
    in_if.epoch_high  <= '0;
    in_if.epoch_low   <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.cache_size <= '0;
    rst_n             <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: reset state, extremes, duplicates, saturating mark,
    // out-of-range capacities and a repeated epoch.
    add_item(ivw_pkg::OP_QUERY, '0, '0, '0, '0, 1'b1, ivw_pkg::STS_NOT_YET);
    add_item(ivw_pkg::OP_QUERY, '0, '0, 64'h1, '0, 1'b1, ivw_pkg::STS_WRONG_EPOCH);
    add_item(ivw_pkg::OP_QUERY, '0, '0, '0, ALL_ONES, 1'b1, ivw_pkg::STS_WRONG_EPOCH);
    add_item(ivw_pkg::OP_PUSH, '0, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1,
             ivw_pkg::STS_ACCEPTED);
    add_item(ivw_pkg::OP_PUSH, ALL_ONES, 64'h0123_4567_89ab_cdef, '0, '0, 1'b1,
             ivw_pkg::STS_ACCEPTED);
    add_item(ivw_pkg::OP_PUSH, '0, 64'h5, '0, '0, 1'b1, ivw_pkg::STS_ACCEPTED);
    add_item(ivw_pkg::OP_QUERY, '0, '0, '0, '0, 1'b1, ivw_pkg::STS_OK, ALL_ONES);
    add_item(OP_NONE, 64'd7, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, ivw_pkg::STS_DROPPED);
    add_cfg(7'd0);
    add_item(ivw_pkg::OP_PUSH, 64'd10, 64'ha, '0, '0);
    add_item(ivw_pkg::OP_PUSH, 64'd11, 64'hb, '0, '0);
    add_item(ivw_pkg::OP_QUERY, 64'd10, '0, '0, '0);
    add_item(ivw_pkg::OP_QUERY, ALL_ONES, '0, '0, '0);
    add_item(ivw_pkg::OP_EPOCH, '0, '0, ALL_ONES, ALL_ONES, 1'b1, ivw_pkg::STS_ACCEPTED);
    add_item(ivw_pkg::OP_QUERY, 64'd10, '0, '0, '0, 1'b1, ivw_pkg::STS_WRONG_EPOCH);
    add_item(ivw_pkg::OP_QUERY, 64'd10, '0, ALL_ONES, ALL_ONES, 1'b1,
             ivw_pkg::STS_NOT_YET);
    add_cfg(7'd127);
    add_item(ivw_pkg::OP_PUSH, 64'd5, 64'h8000_0000_0000_0001, '0, '0, 1'b1,
             ivw_pkg::STS_ACCEPTED);
    add_item(ivw_pkg::OP_QUERY, 64'd5, '0, ALL_ONES, ALL_ONES);
    add_item(ivw_pkg::OP_EPOCH, '0, '0, ALL_ONES, ALL_ONES, 1'b1, ivw_pkg::STS_ACCEPTED);
    add_item(ivw_pkg::OP_QUERY, 64'd5, '0, ALL_ONES, ALL_ONES, 1'b1,
             ivw_pkg::STS_NOT_YET);
    add_cfg(7'd2);
    add_item(ivw_pkg::OP_PUSH, 64'd100, 64'h64, '0, '0);
    add_item(ivw_pkg::OP_PUSH, 64'd200, 64'hc8, '0, '0);
    add_item(ivw_pkg::OP_PUSH, 64'd50, 64'h32, '0, '0);
    add_item(ivw_pkg::OP_QUERY, 64'd100, '0, ALL_ONES, ALL_ONES);
    add_item(ivw_pkg::OP_QUERY, 64'd50, '0, ALL_ONES, ALL_ONES);
    add_item(ivw_pkg::OP_QUERY, 64'd200, '0, ALL_ONES, ALL_ONES);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        wait_all_answered();
        write_capacity(stim_rows[i].cache_size);
      end else begin
        issue(stim_rows[i].req, stim_rows[i].known, stim_rows[i].answer);
      end
    end

    // Random phases; each one pauses halfway until the block has drained.
    for (int p = 0; p < 7; p++) begin
      wait_all_answered();
      write_capacity(ivw_pkg::CFG_W'(phase_cap[p]));
      send_idle_pct = phase_send[p];
      recv_stall_pct = phase_recv[p];
      for (int k = 0; k < phase_items[p]; k++) begin
        if (k == phase_items[p] / 2) wait_all_answered();
        issue(next_random_request(), 1'b0, '0);
      end
    end

    // Let any stray result surface before the verdict.
    wait_all_answered();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && awaited_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ivw_pkg.sv
hw/rtl/ivw_if.sv
hw/rtl/ivw_store.sv
hw/rtl/instance_value_window_cache_unit.sv
verif/instance_value_window_cache_unit_tb.sv
